// File: rtl/pbtd_pkg.sv
`timescale 1ns / 1ps

package pbtd_pkg;

	localparam int ARRIVAL_W = 32;
	localparam int PROCESS_W = 16;
	localparam int START_W   = 32;
	localparam int CFG_W     = 7;

	localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

	typedef struct packed {
		logic [ARRIVAL_W-1:0] arrive_at;
		logic [PROCESS_W-1:0] proc_len;
	} in_item_t;

	typedef struct packed {
		logic               dropped;
		logic [START_W-1:0] start_at;
	} out_item_t;

endpackage

// File: rtl/pbtd_in_if.sv
`timescale 1ns / 1ps

interface pbtd_in_if;
	logic               valid;
	logic               ready;
	pbtd_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/pbtd_out_if.sv
`timescale 1ns / 1ps

interface pbtd_out_if;
	logic                valid;
	logic                ready;
	pbtd_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/pbtd_finish_ram.sv
`timescale 1ns / 1ps

module pbtd_finish_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/packet_buffer_tail_drop_timing_core.sv
`timescale 1ns / 1ps
// result: registered once the scan state has retired each entry finished at or before the arrival
// the scan waits while the output register is held; a new packet is taken only in the idle state
// each retired entry costs one ram read
// a finished result waits in the output register while the next packet is taken
// reset: pointers, count, last finish and state cleared, size back to 64; ram not cleared

module packet_buffer_tail_drop_timing_core #(
	parameter int DEPTH      = 64,
	parameter int TIME_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [pbtd_pkg::CFG_W-1:0] cfg_wr_data,
	pbtd_in_if.sink                    pkt_in,
	pbtd_out_if.source                 pkt_out
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = (CW > pbtd_pkg::CFG_W) ? CW : pbtd_pkg::CFG_W;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t                         state_q;
	logic [TIME_WIDTH-1:0]          arrival_q;
	logic [pbtd_pkg::PROCESS_W-1:0] ptime_q;
	logic [AW-1:0]                  head_q;
	logic [AW-1:0]                  tail_q;
	logic [CW-1:0]                  count_q;
	logic [TIME_WIDTH-1:0]          last_finish_q;
	logic [pbtd_pkg::CFG_W-1:0]     size_q;
	logic                           out_valid_q;
	pbtd_pkg::out_item_t            out_data_q;

	logic [TIME_WIDTH-1:0] rd_data;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         head_next;
	logic [AW-1:0]         tail_next;
	logic                  pop;
	logic                  out_free;
	logic                  decide;
	logic                  empty;
	logic                  full;
	logic                  drop;
	logic [SW-1:0]         size_ext;
	logic [SW-1:0]         size_eff;
	logic [TIME_WIDTH-1:0] start;
	logic [TIME_WIDTH:0]   sum;
	logic [TIME_WIDTH-1:0] finish;
	logic                  wr_en;

	pbtd_finish_ram #(
		.DEPTH (DEPTH),
		.WIDTH (TIME_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data (finish),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// effective size: zero acts as one, clipped at depth
	always_comb begin
		size_ext = SW'(size_q);
		if (size_ext == '0) begin
			size_eff = SW'(1);
		end else if (size_ext > SW'(DEPTH)) begin
			size_eff = SW'(DEPTH);
		end else begin
			size_eff = size_ext;
		end
	end

	assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// retire head entry when it finishes at or before the arrival
	assign pop     = (state_q == S_SCAN) && (count_q != '0) && (arrival_q >= rd_data);
	assign rd_addr = pop ? head_next : head_q;

	assign out_free = !out_valid_q || pkt_out.ready;
	assign decide   = (state_q == S_SCAN) && !pop && out_free;

	assign empty = (count_q == '0);
	assign full  = (SW'(count_q) >= size_eff);
	assign drop  = !empty && full;

	always_comb begin
		if (empty) begin
			start = arrival_q;
		end else if (full) begin
			start = '0;
		end else begin
			start = last_finish_q;
		end
	end

	// saturating finish time
	assign sum    = {1'b0, start} + (TIME_WIDTH + 1)'(ptime_q);
	assign finish = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
	assign wr_en  = decide && !drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= '0;
			tail_q        <= '0;
			count_q       <= '0;
			last_finish_q <= '0;
			size_q        <= pbtd_pkg::CFG_SIZE_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
			if (out_valid_q && pkt_out.ready && !decide) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pkt_in.valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (pop) begin
						head_q  <= head_next;
						count_q <= count_q - 1'b1;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (!drop) begin
							tail_q        <= tail_next;
							count_q       <= count_q + 1'b1;
							last_finish_q <= finish;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && pkt_in.valid) begin
			arrival_q <= TIME_WIDTH'(pkt_in.data.arrive_at);
			ptime_q   <= pkt_in.data.proc_len;
		end
		if (decide) begin
			out_data_q.dropped  <= drop;
			out_data_q.start_at <= pbtd_pkg::START_W'(start);
		end
	end

	assign pkt_in.ready  = (state_q == S_IDLE);
	assign pkt_out.valid = out_valid_q;
	assign pkt_out.data  = out_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0) && (state_q == S_SCAN))
		else $error("retire from empty buffer");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (SW'(count_q) < size_eff))
		else $error("push into full buffer");

	a_result_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_SCAN) && (state_q == S_IDLE))
		else $error("result without a finished scan");

endmodule
